[rtl/bsts_pkg.sv]
// ----------------------------------------------------------------------------
// bsts_pkg
// Types and codes shared by the bitmap test, set and scan block.
// ----------------------------------------------------------------------------
package bsts_pkg;

  localparam logic [2:0] OP_TEST       = 3'd0;
  localparam logic [2:0] OP_TEST_SET   = 3'd1;
  localparam logic [2:0] OP_TEST_RESET = 3'd2;
  localparam logic [2:0] OP_LIST_WORD  = 3'd3;
  localparam logic [2:0] OP_CLEAR_ALL  = 3'd4;

  localparam logic [12:0] CAPACITY_RESET = 13'd4096;

  typedef struct packed {
    logic [2:0]  operation;
    logic [11:0] bit_addr;
    logic [5:0]  word_index;
  } req_t;

  typedef struct packed {
    logic        was_set;
    logic        bit_found;
    logic [11:0] bit_position;
    logic        last;
    logic        range_error;
  } rsp_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SCAN
  } state_t;

endpackage

[rtl/bitmap_test_set_and_scan.sv]
// ----------------------------------------------------------------------------
// bitmap_test_set_and_scan
// Bit-vector store of 64-bit words with test, test-and-set, test-and-reset,
// per-word enumeration of set bits and clear-all.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  bsts_pkg::req_t
//   rsp      out        rsp_valid/rsp_stall  bsts_pkg::rsp_t
//   cfg      in         cfg_we               cfg_wdata (capacity in bits)
//
// A test-type beat first reads the word, then answers and writes it back.
// list_word reads the word, then answers once per set bit found.
// After reset and after clear_all the RAM is swept one word a cycle while
// req_stall stays high. A stalled rsp holds the block in its answering state;
// a new beat is taken while the last rsp waits.
// ----------------------------------------------------------------------------
module bitmap_test_set_and_scan #(
  parameter int WORD_COUNT = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  bsts_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output bsts_pkg::rsp_t  rsp,
  input  logic            cfg_we,
  input  logic [12:0]     cfg_wdata
);

  import bsts_pkg::*;

  localparam int AW     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int CW_MIN = $clog2(WORD_COUNT * 64 + 1);
  localparam int CW     = (CW_MIN > 13) ? CW_MIN : 13;
  localparam logic [CW-1:0] LIMIT     = CW'(WORD_COUNT * 64);
  localparam logic [AW-1:0] LAST_WORD = AW'(WORD_COUNT - 1);

  state_t state, state_next;

  logic [12:0]   capacity;
  logic [AW-1:0] cnt;
  logic [2:0]    op;
  logic          err;
  logic [AW-1:0] addr;
  logic [5:0]    bit_lo;
  logic [11:0]   base;
  logic [63:0]   lim_mask;
  logic [63:0]   scan_word;

  logic          accept;
  logic          out_free;
  logic [CW-1:0] eff_cap;
  logic [CW-1:0] req_base;
  logic [CW-1:0] avail;
  logic [AW-1:0] req_addr;
  logic          req_err;
  logic [63:0]   req_mask;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [63:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [63:0]   ram_rdata;

  logic [63:0]   bit_mask;
  logic [63:0]   masked;
  logic [63:0]   lowest;
  logic [5:0]    low_pos;
  logic          rsp_load;
  rsp_t          rsp_next;

  bsts_ram #(
    .WIDTH(64),
    .DEPTH(WORD_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // request decode and range check
  always_comb begin
    eff_cap  = (CW'(capacity) < LIMIT) ? CW'(capacity) : LIMIT;
    req_base = CW'({req.word_index, 6'b0});
    avail    = eff_cap - req_base;
    if (req.operation == OP_LIST_WORD) begin
      req_addr = AW'(req.word_index);
      req_err  = (req_base >= eff_cap);
    end else begin
      req_addr = AW'(req.bit_addr[11:6]);
      req_err  = (req.operation <= OP_TEST_RESET) && (CW'(req.bit_addr) >= eff_cap);
    end
    if (avail >= CW'(64)) begin
      req_mask = '1;
    end else begin
      req_mask = (64'd1 << avail[5:0]) - 64'd1;
    end
  end

  assign out_free = !rsp_valid || !rsp_stall;
  assign accept   = req_valid && (state == S_IDLE);

  // word handling and lowest set bit
  always_comb begin
    bit_mask = 64'd1 << bit_lo;
    masked   = ram_rdata & lim_mask;
    lowest   = scan_word & (~scan_word + 64'd1);
    low_pos  = '0;
    for (int i = 0; i < 64; i++) begin
      if (lowest[i]) begin
        low_pos = low_pos | 6'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (cnt == LAST_WORD) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (out_free) begin
          if (!err && op == OP_LIST_WORD && masked != '0) begin
            state_next = S_SCAN;
          end else if (op == OP_CLEAR_ALL) begin
            state_next = S_CLEAR;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        if (out_free && (scan_word & ~lowest) == '0) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req_stall = (state != S_IDLE);
    ram_raddr = accept ? req_addr : addr;
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = ram_rdata;
    rsp_load  = 1'b0;
    rsp_next  = '0;
    rsp_next.last = 1'b1;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = '0;
      end
      S_IDLE: begin
      end
      S_READ: begin
        if (out_free) begin
          rsp_load = !(!err && op == OP_LIST_WORD && masked != '0);
          rsp_next.range_error = err;
          if (!err && op <= OP_TEST_RESET) begin
            rsp_next.was_set = |(ram_rdata & bit_mask);
            if (op == OP_TEST_SET) begin
              ram_we    = 1'b1;
              ram_wdata = ram_rdata | bit_mask;
            end else if (op == OP_TEST_RESET) begin
              ram_we    = 1'b1;
              ram_wdata = ram_rdata & ~bit_mask;
            end
          end
        end
      end
      S_SCAN: begin
        rsp_load               = out_free;
        rsp_next.bit_found     = 1'b1;
        rsp_next.bit_position  = base | 12'(low_pos);
        rsp_next.last          = ((scan_word & ~lowest) == '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      capacity  <= CAPACITY_RESET;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (state == S_CLEAR) begin
        cnt <= cnt + AW'(1);
      end else begin
        cnt <= '0;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= req.operation;
      err      <= req_err;
      addr     <= req_addr;
      bit_lo   <= req.bit_addr[5:0];
      base     <= {req.word_index, 6'b0};
      lim_mask <= req_mask;
    end
    if (state == S_READ) begin
      scan_word <= masked;
    end else if (state == S_SCAN && out_free) begin
      scan_word <= scan_word & ~lowest;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

endmodule

[rtl/bsts_ram.sv]
// ----------------------------------------------------------------------------
// bsts_ram
// Simple dual-port RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module bsts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
